@@ hdl/wis_pkg.sv @@
// ----------------------------------------------------------------------------
// wis_pkg
// opcodes, status codes and control/status structs of the i32 stack machine
// ----------------------------------------------------------------------------
package wis_pkg;

  localparam logic [5:0] OP_BEGIN       = 6'd0;
  localparam logic [5:0] OP_ARG         = 6'd1;
  localparam logic [5:0] OP_UNREACHABLE = 6'd2;
  localparam logic [5:0] OP_NOP         = 6'd3;
  localparam logic [5:0] OP_END         = 6'd4;
  localparam logic [5:0] OP_RETURN      = 6'd5;
  localparam logic [5:0] OP_CONST       = 6'd6;
  localparam logic [5:0] OP_LCL_GET     = 6'd7;
  localparam logic [5:0] OP_LCL_SET     = 6'd8;
  localparam logic [5:0] OP_LCL_TEE     = 6'd9;
  localparam logic [5:0] OP_GLB_GET     = 6'd10;
  localparam logic [5:0] OP_GLB_SET     = 6'd11;
  localparam logic [5:0] OP_ADD         = 6'd12;
  localparam logic [5:0] OP_SUB         = 6'd13;
  localparam logic [5:0] OP_MUL         = 6'd14;
  localparam logic [5:0] OP_DIV_S       = 6'd15;
  localparam logic [5:0] OP_DIV_U       = 6'd16;
  localparam logic [5:0] OP_REM_S       = 6'd17;
  localparam logic [5:0] OP_REM_U       = 6'd18;
  localparam logic [5:0] OP_AND         = 6'd19;
  localparam logic [5:0] OP_OR          = 6'd20;
  localparam logic [5:0] OP_XOR         = 6'd21;
  localparam logic [5:0] OP_SHL         = 6'd22;
  localparam logic [5:0] OP_SHR_S       = 6'd23;
  localparam logic [5:0] OP_SHR_U       = 6'd24;
  localparam logic [5:0] OP_ROTL        = 6'd25;
  localparam logic [5:0] OP_ROTR        = 6'd26;
  localparam logic [5:0] OP_EQZ         = 6'd27;
  localparam logic [5:0] OP_EQ          = 6'd28;
  localparam logic [5:0] OP_NE          = 6'd29;
  localparam logic [5:0] OP_LT_S        = 6'd30;
  localparam logic [5:0] OP_LT_U        = 6'd31;
  localparam logic [5:0] OP_GT_S        = 6'd32;
  localparam logic [5:0] OP_GT_U        = 6'd33;
  localparam logic [5:0] OP_LE_S        = 6'd34;
  localparam logic [5:0] OP_LE_U        = 6'd35;
  localparam logic [5:0] OP_GE_S        = 6'd36;
  localparam logic [5:0] OP_GE_U        = 6'd37;
  localparam logic [5:0] OP_CLZ         = 6'd38;
  localparam logic [5:0] OP_CTZ         = 6'd39;
  localparam logic [5:0] OP_POPCNT      = 6'd40;

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_END   = 2'd1;
  localparam logic [1:0] ST_TRAP  = 2'd2;
  localparam logic [1:0] ST_FAULT = 2'd3;

  localparam int TDATA_W = 80;

  typedef struct packed {
    logic accept;
    logic rd_a;
    logic rd_b;
    logic exec;
    logic div_wb;
    logic top_rd;
    logic out_load;
  } wis_cmd_t;

  typedef struct packed {
    logic go_div;
    logic div_done;
    logic out_free;
  } wis_sts_t;

endpackage

@@ hdl/wis_ram.sv @@
// ----------------------------------------------------------------------------
// wis_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module wis_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/wis_div.sv @@
// ----------------------------------------------------------------------------
// wis_div
// 32 bit unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wis_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);

  logic [31:0] q_r, q_nxt;
  logic [31:0] rm_r, rm_nxt;
  logic [31:0] dv_r;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    q_nxt    = q_r;
    rm_nxt   = rm_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rm_r, q_r[31]};
    if (start) begin
      q_nxt    = dividend;
      rm_nxt   = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dv_r}) begin
        rm_nxt = 32'(trial - {1'b0, dv_r});
        q_nxt  = {q_r[30:0], 1'b1};
      end else begin
        rm_nxt = trial[31:0];
        q_nxt  = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r  <= q_nxt;
    rm_r <= rm_nxt;
    if (start) begin
      dv_r <= divisor;
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rm_r;

endmodule

@@ hdl/wis_ctrl.sv @@
// ----------------------------------------------------------------------------
// wis_ctrl
// instruction sequencer: operand reads, execute, divide wait, top read, result
// ----------------------------------------------------------------------------
module wis_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  wis_pkg::wis_sts_t sts,
  output wis_pkg::wis_cmd_t cmd
);
  import wis_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RDA  = 7'b0000010,
    S_RDB  = 7'b0000100,
    S_EXEC = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_TOP  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_RDA;
        end
      end
      S_RDA: begin
        cmd.rd_a  = 1'b1;
        state_nxt = S_RDB;
      end
      S_RDB: begin
        cmd.rd_b  = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.go_div ? S_DIV : S_TOP;
      end
      S_DIV: begin
        cmd.div_wb = sts.div_done;
        if (sts.div_done) begin
          state_nxt = S_TOP;
        end
      end
      S_TOP: begin
        cmd.top_rd = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        cmd.out_load = sts.out_free;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

@@ hdl/wis_dp.sv @@
// ----------------------------------------------------------------------------
// wis_dp
// stack memory, stack pointer, status, local flags, i32 alu and divider
// ----------------------------------------------------------------------------
module wis_dp #(
  parameter int STACK_DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  wis_pkg::wis_cmd_t               cmd,
  output wis_pkg::wis_sts_t               sts,
  input  logic [wis_pkg::TDATA_W-1:0]     in_tdata,
  input  logic                            cfg_we,
  input  logic [7:0]                      cfg_wdata,
  input  logic                            out_tready,
  output logic                            out_tvalid,
  output logic [wis_pkg::TDATA_W-1:0]     out_tdata
);
  import wis_pkg::*;

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int CW  = SPW + 9;

  logic [5:0]   func_r;
  logic [7:0]   idx_r;
  logic [63:0]  imm_r;
  logic [63:0]  b_r;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [1:0]   st_r, st_nxt;
  logic [7:0]   lc_r;
  logic [255:0] lw_r;
  logic         lw_set, lw_clr;
  logic [5:0]   dop_r;
  logic         na_r, nb_r;
  logic [AW-1:0] wb_addr_r;
  logic         out_valid_r;
  logic [1:0]   out_status_r;
  logic [63:0]  out_top_r;
  logic [8:0]   out_depth_r;

  logic [SPW-1:0] spm1, spm2;
  logic [AW-1:0]  idx_addr;
  logic [CW-1:0]  spc, lcc, d;
  logic         local_ok;

  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [63:0]    ram_wdata, ram_rdata;

  logic [31:0] a, b, ma, mb, alu, unr;
  logic [4:0]  s;
  logic        is_div, div_trap, go_div;
  logic        ex_we;
  logic [AW-1:0] ex_waddr;
  logic [63:0] ex_wdata;
  logic        do_push;
  logic [63:0] push_val;
  logic [5:0]  clz, ctz, pop;

  logic        div_done;
  logic [31:0] quo, rem, div_res;

  assign spm1     = sp_r - SPW'(1);
  assign spm2     = sp_r - SPW'(2);
  assign idx_addr = AW'(idx_r);
  assign spc      = CW'(sp_r);
  assign lcc      = CW'(lc_r);
  assign d        = (spc > lcc) ? spc - lcc : '0;
  assign local_ok = (idx_r < lc_r) && (int'(idx_r) < STACK_DEPTH);

  // read port: first operand or local, second operand, new top
  always_comb begin
    ram_re    = cmd.rd_a | cmd.rd_b | cmd.top_rd;
    ram_raddr = spm1[AW-1:0];
    if (cmd.rd_a && func_r == OP_LCL_GET) begin
      ram_raddr = idx_addr;
    end else if (cmd.rd_b) begin
      ram_raddr = spm2[AW-1:0];
    end
  end

  assign b  = b_r[31:0];
  assign a  = ram_rdata[31:0];
  assign s  = b[4:0];
  assign ma = a[31] ? 32'd0 - a : a;
  assign mb = b[31] ? 32'd0 - b : b;

  always_comb begin
    clz = 6'd32;
    ctz = 6'd32;
    pop = '0;
    for (int i = 0; i < 32; i++) begin
      if (b[i]) begin
        clz = 6'(31 - i);
      end
      pop = pop + 6'(b[i]);
    end
    for (int j = 31; j >= 0; j--) begin
      if (b[j]) begin
        ctz = 6'(j);
      end
    end
  end

  always_comb begin
    case (func_r)
      OP_EQZ:  unr = {31'd0, b == 32'd0};
      OP_CLZ:  unr = {26'd0, clz};
      OP_CTZ:  unr = {26'd0, ctz};
      default: unr = {26'd0, pop};
    endcase
  end

  always_comb begin
    case (func_r)
      OP_ADD:   alu = a + b;
      OP_SUB:   alu = a - b;
      OP_MUL:   alu = a * b;
      OP_AND:   alu = a & b;
      OP_OR:    alu = a | b;
      OP_XOR:   alu = a ^ b;
      OP_SHL:   alu = a << s;
      OP_SHR_S: alu = $unsigned($signed(a) >>> s);
      OP_SHR_U: alu = a >> s;
      OP_ROTL:  alu = (s == 5'd0) ? a : (a << s) | (a >> (6'd32 - {1'b0, s}));
      OP_ROTR:  alu = (s == 5'd0) ? a : (a >> s) | (a << (6'd32 - {1'b0, s}));
      OP_EQ:    alu = {31'd0, a == b};
      OP_NE:    alu = {31'd0, a != b};
      OP_LT_S:  alu = {31'd0, $signed(a) < $signed(b)};
      OP_LT_U:  alu = {31'd0, a < b};
      OP_GT_S:  alu = {31'd0, $signed(a) > $signed(b)};
      OP_GT_U:  alu = {31'd0, a > b};
      OP_LE_S:  alu = {31'd0, $signed(a) <= $signed(b)};
      OP_LE_U:  alu = {31'd0, a <= b};
      OP_GE_S:  alu = {31'd0, $signed(a) >= $signed(b)};
      default:  alu = {31'd0, a >= b};
    endcase
  end

  assign is_div   = (func_r == OP_DIV_S) || (func_r == OP_DIV_U) ||
                    (func_r == OP_REM_S) || (func_r == OP_REM_U);
  assign div_trap = (b == 32'd0) ||
                    (func_r == OP_DIV_S && a == 32'h8000_0000 && b == 32'hFFFF_FFFF);

  // execute step
  always_comb begin
    sp_nxt   = sp_r;
    st_nxt   = st_r;
    ex_we    = 1'b0;
    ex_waddr = spm1[AW-1:0];
    ex_wdata = {32'd0, unr};
    lw_set   = 1'b0;
    lw_clr   = 1'b0;
    go_div   = 1'b0;
    do_push  = 1'b0;
    push_val = imm_r;
    if (func_r == OP_BEGIN) begin
      lw_clr = 1'b1;
      if (int'(lc_r) > STACK_DEPTH) begin
        sp_nxt = '0;
        st_nxt = ST_FAULT;
      end else begin
        sp_nxt = SPW'(lc_r);
        st_nxt = ST_RUN;
      end
    end else if (st_r == ST_RUN) begin
      case (func_r) inside
        OP_ARG: begin
          if (!local_ok) begin
            st_nxt = ST_FAULT;
          end else begin
            ex_we    = 1'b1;
            ex_waddr = idx_addr;
            ex_wdata = imm_r;
            lw_set   = 1'b1;
          end
        end
        OP_NOP: begin
        end
        OP_END, OP_RETURN: begin
          st_nxt = ST_END;
        end
        OP_CONST: begin
          do_push = 1'b1;
        end
        OP_LCL_GET: begin
          if (!local_ok) begin
            st_nxt = ST_FAULT;
          end else begin
            do_push  = 1'b1;
            push_val = lw_r[idx_r] ? b_r : 64'd0;
          end
        end
        OP_LCL_SET, OP_LCL_TEE: begin
          if (!local_ok || d == '0) begin
            st_nxt = ST_FAULT;
          end else begin
            ex_we    = 1'b1;
            ex_waddr = idx_addr;
            ex_wdata = b_r;
            lw_set   = 1'b1;
            if (func_r == OP_LCL_SET) begin
              sp_nxt = spm1;
            end
          end
        end
        OP_GLB_GET: begin
          do_push  = 1'b1;
          push_val = 64'd0;
        end
        OP_GLB_SET: begin
          if (d == '0) begin
            st_nxt = ST_FAULT;
          end else begin
            sp_nxt = spm1;
          end
        end
        OP_EQZ, OP_CLZ, OP_CTZ, OP_POPCNT: begin
          if (d == '0) begin
            st_nxt = ST_FAULT;
          end else begin
            ex_we = 1'b1;
          end
        end
        [OP_ADD:OP_GE_U]: begin
          if (d < CW'(2)) begin
            st_nxt = ST_FAULT;
          end else begin
            sp_nxt   = spm1;
            ex_waddr = spm2[AW-1:0];
            ex_wdata = {32'd0, alu};
            if (!is_div) begin
              ex_we = 1'b1;
            end else if (div_trap) begin
              st_nxt = ST_TRAP;
            end else begin
              go_div = 1'b1;
            end
          end
        end
        default: begin
          st_nxt = ST_TRAP;
        end
      endcase
      if (do_push) begin
        if (int'(sp_r) >= STACK_DEPTH) begin
          st_nxt = ST_FAULT;
        end else begin
          ex_we    = 1'b1;
          ex_waddr = sp_r[AW-1:0];
          ex_wdata = push_val;
          sp_nxt   = sp_r + SPW'(1);
        end
      end
    end
  end

  wis_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.exec & go_div),
    .dividend  ((func_r == OP_DIV_S || func_r == OP_REM_S) ? ma : a),
    .divisor   ((func_r == OP_DIV_S || func_r == OP_REM_S) ? mb : b),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  always_comb begin
    case (dop_r)
      OP_DIV_S: div_res = (na_r != nb_r) ? 32'd0 - quo : quo;
      OP_REM_S: div_res = na_r ? 32'd0 - rem : rem;
      OP_DIV_U: div_res = quo;
      default:  div_res = rem;
    endcase
  end

  assign ram_we    = (cmd.exec & ex_we) | cmd.div_wb;
  assign ram_waddr = cmd.div_wb ? wb_addr_r : ex_waddr;
  assign ram_wdata = cmd.div_wb ? {32'd0, div_res} : ex_wdata;

  wis_ram #(
    .WIDTH (64),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      st_r        <= ST_END;
      lc_r        <= '0;
      lw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        lc_r <= cfg_wdata;
      end
      if (cmd.exec) begin
        sp_r <= sp_nxt;
        st_r <= st_nxt;
        if (lw_clr) begin
          lw_r <= '0;
        end else if (lw_set) begin
          lw_r[idx_r] <= 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r <= in_tdata[5:0];
      idx_r  <= in_tdata[13:6];
      imm_r  <= in_tdata[77:14];
    end
    if (cmd.rd_b) begin
      b_r <= ram_rdata;
    end
    if (cmd.exec) begin
      dop_r     <= func_r;
      na_r      <= a[31];
      nb_r      <= b[31];
      wb_addr_r <= spm2[AW-1:0];
    end
    if (cmd.out_load) begin
      out_status_r <= st_r;
      out_top_r    <= (d != '0) ? ram_rdata : 64'd0;
      out_depth_r  <= 9'(d);
    end
  end

  assign sts.go_div   = go_div;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_depth_r, out_top_r, out_status_r};

endmodule

@@ hdl/wasm_i32_stack_machine_top.sv @@
// ----------------------------------------------------------------------------
// wasm_i32_stack_machine_top
// i32 stack machine executing one instruction per input word
// steps: accept, operand reads, execute, div/rem wait, top read, result load
// one word in flight: the next is taken once the result loads; paced by the
//   single read port of the stack ram and the one bit per cycle divider
// reset: synchronous active low; status reads ended, stack pointer and
//   local count zero; stack ram contents are not cleared
// ----------------------------------------------------------------------------
module wasm_i32_stack_machine_top #(
  parameter int STACK_DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // func[5:0], index[13:6], immediate[77:14], zero pad
  input  logic [wis_pkg::TDATA_W-1:0] in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // status[1:0], top_value[65:2], operand_depth[74:66], zero pad
  output logic [wis_pkg::TDATA_W-1:0] out_tdata,
  input  logic                        cfg_we,
  input  logic [7:0]                  cfg_wdata
);
  import wis_pkg::*;

  wis_cmd_t cmd;
  wis_sts_t sts;

  wis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wis_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

  // one word in flight
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a word is in flight");

  // no result straight after reset
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a result is only loaded in the final step, never alongside an accept
  assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.out_load && cmd.accept))
    else $error("result load and accept in the same cycle");

endmodule

@@ tb/sv/wasm_i32_stack_machine_top_tb.sv @@
// ----------------------------------------------------------------------------
// wasm_i32_stack_machine_top_tb
// self-checking bench for the i32 stack machine: a short table of directed
// words, then random programs under several local counts and handshake
// idling phases, each result checked field by field against the table or a predictor
// ----------------------------------------------------------------------------
module wasm_i32_stack_machine_top_tb;
  import wis_pkg::*;

  localparam int DEPTH     = 256;
  localparam int CYC_LIMIT = 1000000;
  localparam int SETTLE    = 50;

  localparam logic [5:0] OP_UNDEF = 6'd63;

  typedef struct packed {
    logic [8:0]  depth;
    logic [63:0] top;
    logic [1:0]  status;
  } mach_res_t;

  typedef struct {
    logic [5:0]  op;
    logic [7:0]  idx;
    logic [63:0] imm;
    bit          typed;
    mach_res_t   res;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [TDATA_W-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [TDATA_W-1:0]  out_tdata;
  logic                cfg_we = 1'b0;
  logic [7:0]          cfg_wdata = '0;

  // machine state mirrored by the predictor
  logic [63:0] stk_mem [DEPTH];
  bit          loc_wr [256];
  int          sp;
  logic [1:0]  run_st;
  int          loc_cnt;

  mach_res_t   res_q[$];
  int          err_cnt, res_cnt, word_cnt, cyc;
  int          tx_idle, rx_stall;
  bit          hold_kick;
  int          hold_left;

  wasm_i32_stack_machine_top #(.STACK_DEPTH(DEPTH)) u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .cfg_we, .cfg_wdata
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYC_LIMIT) begin
      $display("timeout after %0d cycles", cyc);
      $display("wasm_i32_stack_machine_top_tb: errors");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_kick && hold_left == 0) begin
      hold_left  <= 400;
      out_tready <= 1'b0;
    end else if (hold_left > 1) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      if (hold_left == 1) hold_left <= -1;
      out_tready <= ($urandom_range(99) >= rx_stall);
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    err_cnt++;
    $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, exp, res_cnt);
  endtask

  always @(posedge clk) begin
    mach_res_t got, exp;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[74:0];
      if (res_q.size() == 0) begin
        report("unexpected word", got.top, 64'd0);
      end else begin
        exp = res_q.pop_front();
        if (got.status != exp.status) report("status", 64'(got.status), 64'(exp.status));
        if (got.top != exp.top) report("top_value", got.top, exp.top);
        if (got.depth != exp.depth) report("operand_depth", 64'(got.depth), 64'(exp.depth));
      end
      res_cnt++;
    end
  end

  function automatic int oper_depth();
    return (sp > loc_cnt) ? sp - loc_cnt : 0;
  endfunction

  function automatic void push_val(input logic [63:0] v);
    if (sp >= DEPTH) begin
      run_st = ST_FAULT;
    end else begin
      stk_mem[sp] = v;
      sp++;
    end
  endfunction

  function automatic logic [31:0] bit_count(input logic [5:0] op, input logic [31:0] a);
    int n;
    n = 0;
    if (op == OP_CLZ) begin
      while (n < 32 && !a[31-n]) n++;
    end else if (op == OP_CTZ) begin
      while (n < 32 && !a[n]) n++;
    end else begin
      for (int i = 0; i < 32; i++) n += a[i];
    end
    return 32'(n);
  endfunction

  // returns 0 on a division trap
  function automatic bit i32_binop(input logic [5:0] op, input logic [31:0] a,
                                   input logic [31:0] b, output logic [31:0] r);
    logic signed [31:0] sa, sb;
    logic [4:0] s;
    sa = a;
    sb = b;
    s  = b[4:0];
    r  = '0;
    case (op)
      OP_ADD:    r = a + b;
      OP_SUB:    r = a - b;
      OP_MUL:    r = a * b;
      OP_DIV_S: begin
        if (b == 0 || (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)) return 1'b0;
        r = sa / sb;
      end
      OP_DIV_U: begin
        if (b == 0) return 1'b0;
        r = a / b;
      end
      OP_REM_S: begin
        if (b == 0) return 1'b0;
        if (b == 32'hFFFF_FFFF) r = '0;
        else r = sa % sb;
      end
      OP_REM_U: begin
        if (b == 0) return 1'b0;
        r = a % b;
      end
      OP_AND:    r = a & b;
      OP_OR:     r = a | b;
      OP_XOR:    r = a ^ b;
      OP_SHL:    r = a << s;
      OP_SHR_S:  r = sa >>> s;
      OP_SHR_U:  r = a >> s;
      OP_ROTL:   r = (s == 0) ? a : (a << s) | (a >> (32 - s));
      OP_ROTR:   r = (s == 0) ? a : (a >> s) | (a << (32 - s));
      OP_EQ:     r = {31'd0, a == b};
      OP_NE:     r = {31'd0, a != b};
      OP_LT_S:   r = {31'd0, sa < sb};
      OP_LT_U:   r = {31'd0, a < b};
      OP_GT_S:   r = {31'd0, sa > sb};
      OP_GT_U:   r = {31'd0, a > b};
      OP_LE_S:   r = {31'd0, sa <= sb};
      OP_LE_U:   r = {31'd0, a <= b};
      OP_GE_S:   r = {31'd0, sa >= sb};
      default:   r = {31'd0, a >= b};
    endcase
    return 1'b1;
  endfunction

  function automatic void exec_instr(input logic [5:0] op, input logic [7:0] idx,
                                     input logic [63:0] imm);
    int d;
    bit ok;
    logic [31:0] a, b, r;
    d  = oper_depth();
    ok = idx < loc_cnt;
    case (op)
      OP_ARG: begin
        if (!ok) run_st = ST_FAULT;
        else begin
          stk_mem[idx] = imm;
          loc_wr[idx] = 1;
        end
      end
      OP_UNREACHABLE: run_st = ST_TRAP;
      OP_NOP: ;
      OP_END, OP_RETURN: run_st = ST_END;
      OP_CONST: push_val(imm);
      OP_LCL_GET: begin
        if (!ok) run_st = ST_FAULT;
        else push_val(loc_wr[idx] ? stk_mem[idx] : 64'd0);
      end
      OP_LCL_SET, OP_LCL_TEE: begin
        if (!ok || d < 1) run_st = ST_FAULT;
        else begin
          stk_mem[idx] = stk_mem[sp-1];
          loc_wr[idx] = 1;
          if (op == OP_LCL_SET) sp--;
        end
      end
      OP_GLB_GET: push_val(64'd0);
      OP_GLB_SET: begin
        if (d < 1) run_st = ST_FAULT;
        else sp--;
      end
      OP_EQZ, OP_CLZ, OP_CTZ, OP_POPCNT: begin
        if (d < 1) run_st = ST_FAULT;
        else begin
          a = stk_mem[sp-1][31:0];
          stk_mem[sp-1] = (op == OP_EQZ) ? {63'd0, a == 0} : {32'd0, bit_count(op, a)};
        end
      end
      default: begin
        if (op < OP_ADD || op > OP_POPCNT) run_st = ST_TRAP;
        else if (d < 2) run_st = ST_FAULT;
        else begin
          b = stk_mem[sp-1][31:0];
          a = stk_mem[sp-2][31:0];
          sp--;
          if (!i32_binop(op, a, b, r)) run_st = ST_TRAP;
          else stk_mem[sp-1] = {32'd0, r};
        end
      end
    endcase
  endfunction

  function automatic mach_res_t predict_machine(input logic [5:0] op, input logic [7:0] idx,
                                                input logic [63:0] imm);
    mach_res_t res;
    int d;
    if (op == OP_BEGIN) begin
      foreach (loc_wr[i]) loc_wr[i] = 0;
      if (loc_cnt > DEPTH) begin
        sp = 0;
        run_st = ST_FAULT;
      end else begin
        sp = loc_cnt;
        run_st = ST_RUN;
      end
    end else if (run_st == ST_RUN) begin
      exec_instr(op, idx, imm);
    end
    d = oper_depth();
    res.status = run_st;
    res.top    = d ? stk_mem[sp-1] : 64'd0;
    res.depth  = d[8:0];
    return res;
  endfunction

  task automatic send_word(input logic [5:0] op, input logic [7:0] idx,
                           input logic [63:0] imm);
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, imm, idx, op};
    do @(posedge clk); while (!in_tready);
    word_cnt++;
  endtask

  // a lower local count restarts the machine so no stale slot becomes the top
  task automatic settle_and_config(input int lc);
    bit lower;
    lower = lc < loc_cnt;
    in_tvalid <= 1'b0;
    while (res_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= lc[7:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    loc_cnt = lc;
    if (lower) begin
      res_q.push_back(predict_machine(OP_BEGIN, 8'd0, 64'd0));
      send_word(OP_BEGIN, 8'd0, 64'd0);
    end
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(7))
      0: return 64'd0;
      1: return 64'd1;
      2: return 64'h0000_0000_FFFF_FFFF;
      3: return 64'h0000_0000_8000_0000;
      4: return 64'h0000_0000_7FFF_FFFF;
      5: return {32'd0, 27'd0, 5'($urandom)};
      6: return {32'd0, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [7:0] pick_local();
    if (loc_cnt > 0 && $urandom_range(9) != 0) return 8'($urandom_range(loc_cnt - 1));
    return 8'($urandom_range(255));
  endfunction

  // random programs: begin, args, then mostly operand-balanced instructions
  task automatic run_programs(input int n);
    int done;
    int r, d;
    logic [5:0] op;
    done = 0;
    while (done < n) begin
      d = oper_depth();
      r = $urandom_range(99);
      if (run_st != ST_RUN) op = (r < 90) ? OP_BEGIN : 6'($urandom_range(1, 63));
      else if (r < 2) op = 6'($urandom_range(41, 63));
      else if (r < 5) op = 6'($urandom_range(OP_UNREACHABLE, OP_RETURN));
      else if (r < 7) op = OP_BEGIN;
      else if (r < 15) op = OP_ARG;
      else if (d < 2 && r < 70) begin
        case ($urandom_range(3))
          0: op = OP_LCL_GET;
          1: op = OP_GLB_GET;
          default: op = OP_CONST;
        endcase
      end else op = 6'($urandom_range(OP_CONST, OP_POPCNT));
      if (run_st == ST_RUN || op == OP_BEGIN) done++;
      begin
        logic [7:0]  idx;
        logic [63:0] imm;
        idx = pick_local();
        imm = pick_value();
        res_q.push_back(predict_machine(op, idx, imm));
        send_word(op, idx, imm);
      end
    end
  endtask

  dir_row_t dir_tab[$];

  function automatic void add_row(input logic [5:0] op, input logic [7:0] idx,
                                  input logic [63:0] imm, input bit typed = 0,
                                  input logic [1:0] st = 0, input logic [63:0] top = 0,
                                  input logic [8:0] dp = 0);
    dir_row_t row;
    row.op = op; row.idx = idx; row.imm = imm; row.typed = typed;
    row.res.status = st;
    row.res.top    = top;
    row.res.depth  = dp;
    dir_tab.push_back(row);
  endfunction

  initial begin
    mach_res_t pr;
    foreach (stk_mem[i]) stk_mem[i] = '0;
    foreach (loc_wr[i]) loc_wr[i] = 0;
    sp = 0; run_st = ST_END; loc_cnt = 0;
    tx_idle = 0; rx_stall = 0; hold_kick = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    settle_and_config(2);

    add_row(OP_NOP, 0, 0, 1, ST_END, 0, 0);
    add_row(OP_BEGIN, 0, 0, 1, ST_RUN, 0, 0);
    add_row(OP_LCL_GET, 0, 0, 1, ST_RUN, 0, 1);
    add_row(OP_ARG, 1, '1);
    add_row(OP_LCL_GET, 1, 0);
    add_row(OP_LCL_TEE, 0, 0);
    add_row(OP_CONST, 0, 64'h0000_0000_8000_0000);
    add_row(OP_CONST, 0, 64'h0000_0000_FFFF_FFFF);
    add_row(OP_REM_S, 0, 0);
    add_row(OP_CONST, 0, 64'h0000_0000_8000_0000);
    add_row(OP_CONST, 0, 64'h0000_0000_FFFF_FFFF);
    add_row(OP_DIV_S, 0, 0, 1, ST_TRAP, 64'h0000_0000_8000_0000, 4);
    add_row(OP_BEGIN, 0, 0, 1, ST_RUN, 0, 0);
    add_row(OP_CONST, 0, 64'd7);
    add_row(OP_CONST, 0, 64'd0);
    add_row(OP_DIV_U, 0, 0, 1, ST_TRAP, 64'd7, 1);
    add_row(OP_BEGIN, 0, 0);
    add_row(OP_CONST, 0, 64'h0000_0000_8000_0001);
    add_row(OP_ROTL, 0, 0, 1, ST_FAULT, 64'h0000_0000_8000_0001, 1);
    add_row(OP_BEGIN, 0, 0);
    add_row(OP_LCL_GET, 200, 0, 1, ST_FAULT, 0, 0);
    add_row(OP_BEGIN, 0, 0);
    add_row(OP_UNDEF, 0, 0, 1, ST_TRAP, 0, 0);
    add_row(OP_BEGIN, 0, 0);
    add_row(OP_RETURN, 0, 0, 1, ST_END, 0, 0);

    foreach (dir_tab[i]) begin
      pr = predict_machine(dir_tab[i].op, dir_tab[i].idx, dir_tab[i].imm);
      res_q.push_back(dir_tab[i].typed ? dir_tab[i].res : pr);
      send_word(dir_tab[i].op, dir_tab[i].idx, dir_tab[i].imm);
    end

    settle_and_config(255);
    run_programs(150);

    settle_and_config(0);
    tx_idle = 68;
    run_programs(250);

    settle_and_config(4);
    tx_idle = 0; rx_stall = 68;
    run_programs(300);

    settle_and_config(1);
    tx_idle = 7; rx_stall = 7;
    run_programs(300);

    settle_and_config(6);
    tx_idle = 0; rx_stall = 0;
    hold_kick = 1;
    run_programs(300);

    in_tvalid <= 1'b0;
    while (res_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("%0d words sent over local counts 0, 1, 2, 4, 6 and 255", word_cnt);
    $display("%0d results checked under five handshake idling phases", res_cnt);
    if (err_cnt == 0) begin
      $display("wasm_i32_stack_machine_top_tb: clean");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("wasm_i32_stack_machine_top_tb: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/wis_pkg.sv
hdl/wis_ram.sv
hdl/wis_div.sv
hdl/wis_ctrl.sv
hdl/wis_dp.sv
hdl/wasm_i32_stack_machine_top.sv
tb/sv/wasm_i32_stack_machine_top_tb.sv
